// ===== src/crl_pkg.sv =====
// crl_pkg: shared types and constants for the cursor linked ring
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package crl_pkg;

    localparam int NODE_COUNT_DEF  = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_NEXT = 3'd0,
        FN_PUSH_PREV = 3'd1,
        FN_MOVE_NEXT = 3'd2,
        FN_MOVE_PREV = 3'd3,
        FN_READ      = 3'd4,
        FN_RENAME    = 3'd5,
        FN_DELETE    = 3'd6,
        FN_REWIND    = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_START = 2'd2
    } status_t;

    // write strobes into the node memories
    typedef struct packed {
        logic wr_next;
        logic wr_prev;
        logic wr_val;
    } node_wr_t;

    // requests to the free slot pool
    typedef struct packed {
        logic take;
        logic give;
    } pool_cmd_t;

endpackage

// ===== src/cursor_linked_ring.sv =====
// cursor_linked_ring: top level of the circular doubly linked ring with a cursor
// depends on crl_pkg, crl_node_mem, crl_free_pool and crl_ctrl
`timescale 1ns / 1ps

// usage
// - item channel (item_valid/item_ready, func, item_value) takes one operation per
//   transaction; result channel (result_valid/result_ready) returns exactly one result
//   per operation: value at the cursor, status, at_start and ring_size.
// - the sequencer steps each operation through the registered node memories, which share
//   one read address: execute, splice (successful pushes only), fetch at the new cursor,
//   load result.
// - item_ready is high only while the sequencer is idle, so a new item is taken only after
//   the previous result has been loaded into the output register.
// - the result sits in an output register, so item_ready returns even when the receiver
//   stalls; a following result waits in the load step until the register is taken.
// - reset: cursor on the start node, size 1, start node linked to itself with value 0,
//   no free slot recycled; no clearing pass, the block is ready right after reset.
// - NODE_COUNT sets the node memory depth, VALUE_WIDTH the stored value width.
module cursor_linked_ring #(
    parameter int NODE_COUNT  = crl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = crl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [crl_pkg::FUNC_W-1:0]    func,
    input  logic [crl_pkg::ITEM_W-1:0]    item_value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [crl_pkg::ITEM_W-1:0]    current_value,
    output logic [crl_pkg::STATUS_W-1:0]  status,
    output logic                          at_start,
    output logic [crl_pkg::SIZE_W-1:0]    ring_size
);
    import crl_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       rd_next;
    logic [IDX_W-1:0]       rd_prev;
    logic [VALUE_WIDTH-1:0] rd_val;
    node_wr_t               wr;
    logic [IDX_W-1:0]       wa_next, wd_next;
    logic [IDX_W-1:0]       wa_prev, wd_prev;
    logic [IDX_W-1:0]       wa_val;
    logic [VALUE_WIDTH-1:0] wd_val;
    pool_cmd_t              pool_cmd;
    logic [IDX_W-1:0]       give_slot;
    logic [IDX_W-1:0]       free_slot;
    logic                   avail;

    crl_node_mem #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_node_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .rd_val  (rd_val),
        .wr      (wr),
        .wa_next (wa_next),
        .wd_next (wd_next),
        .wa_prev (wa_prev),
        .wd_prev (wd_prev),
        .wa_val  (wa_val),
        .wd_val  (wd_val)
    );

    crl_free_pool #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_free_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pool_cmd),
        .give_slot (give_slot),
        .free_slot (free_slot),
        .avail     (avail)
    );

    crl_ctrl #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .item_value    (item_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .current_value (current_value),
        .status        (status),
        .at_start      (at_start),
        .ring_size     (ring_size),
        .rd_addr       (rd_addr),
        .rd_next       (rd_next),
        .rd_prev       (rd_prev),
        .rd_val        (rd_val),
        .wr            (wr),
        .wa_next       (wa_next),
        .wd_next       (wd_next),
        .wa_prev       (wa_prev),
        .wd_prev       (wd_prev),
        .wa_val        (wa_val),
        .wd_val        (wd_val),
        .pool_cmd      (pool_cmd),
        .give_slot     (give_slot),
        .free_slot     (free_slot),
        .avail         (avail)
    );

endmodule

// ===== src/crl_node_mem.sv =====
// crl_node_mem: next link, previous link and value memories of the ring
// depends on crl_pkg; one shared registered read address, one write port per memory
`timescale 1ns / 1ps

module crl_node_mem #(
    parameter int NODE_COUNT  = crl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = crl_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [IDX_W-1:0]       rd_next,
    output logic [IDX_W-1:0]       rd_prev,
    output logic [VALUE_WIDTH-1:0] rd_val,
    input  crl_pkg::node_wr_t      wr,
    input  logic [IDX_W-1:0]       wa_next,
    input  logic [IDX_W-1:0]       wd_next,
    input  logic [IDX_W-1:0]       wa_prev,
    input  logic [IDX_W-1:0]       wd_prev,
    input  logic [IDX_W-1:0]       wa_val,
    input  logic [VALUE_WIDTH-1:0] wd_val
);
    import crl_pkg::*;

    logic [IDX_W-1:0]       next_mem [NODE_COUNT];
    logic [IDX_W-1:0]       prev_mem [NODE_COUNT];
    logic [VALUE_WIDTH-1:0] val_mem  [NODE_COUNT];

    logic [IDX_W-1:0]       next_q_reg;
    logic [IDX_W-1:0]       prev_q_reg;
    logic [VALUE_WIDTH-1:0] val_q_reg;

    // slot 0 reads as zero until it is first written
    logic w0_next_reg, w0_prev_reg, w0_val_reg;
    logic z_next_reg, z_prev_reg, z_val_reg;
    logic rd_zero;

    assign rd_zero = (rd_addr == '0);

    always_ff @(posedge clk)
    begin
        if (wr.wr_next)
        begin
            next_mem[wa_next] <= wd_next;
        end
        if (wr.wr_prev)
        begin
            prev_mem[wa_prev] <= wd_prev;
        end
        if (wr.wr_val)
        begin
            val_mem[wa_val] <= wd_val;
        end
        next_q_reg <= next_mem[rd_addr];
        prev_q_reg <= prev_mem[rd_addr];
        val_q_reg  <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_next_reg <= 1'b0;
            w0_prev_reg <= 1'b0;
            w0_val_reg  <= 1'b0;
            z_next_reg  <= 1'b1;
            z_prev_reg  <= 1'b1;
            z_val_reg   <= 1'b1;
        end
        else
        begin
            if (wr.wr_next && wa_next == '0)
            begin
                w0_next_reg <= 1'b1;
            end
            if (wr.wr_prev && wa_prev == '0)
            begin
                w0_prev_reg <= 1'b1;
            end
            if (wr.wr_val && wa_val == '0)
            begin
                w0_val_reg <= 1'b1;
            end
            z_next_reg <= rd_zero && !w0_next_reg;
            z_prev_reg <= rd_zero && !w0_prev_reg;
            z_val_reg  <= rd_zero && !w0_val_reg;
        end
    end

    assign rd_next = z_next_reg ? '0 : next_q_reg;
    assign rd_prev = z_prev_reg ? '0 : prev_q_reg;
    assign rd_val  = z_val_reg  ? '0 : val_q_reg;

endmodule

// ===== src/crl_free_pool.sv =====
// crl_free_pool: free slot supply, a stack of recycled slots then a fresh mark
// depends on crl_pkg; the stack top is read every cycle into a register
`timescale 1ns / 1ps

module crl_free_pool #(
    parameter int NODE_COUNT = crl_pkg::NODE_COUNT_DEF,
    parameter int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
    parameter int CNT_W      = $clog2(NODE_COUNT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  crl_pkg::pool_cmd_t cmd,
    input  logic [IDX_W-1:0]   give_slot,
    output logic [IDX_W-1:0]   free_slot,
    output logic               avail
);
    import crl_pkg::*;

    logic [IDX_W-1:0] stack_mem [NODE_COUNT];
    logic [IDX_W-1:0] top_reg;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] fm_reg, fm_next;
    logic [CNT_W-1:0] rc_m1;
    logic             stack_empty;
    logic             stack_full;

    assign rc_m1       = rc_reg - 1'b1;
    assign stack_empty = (rc_reg == '0);
    assign stack_full  = (rc_reg >= CNT_W'(NODE_COUNT));

    assign avail     = !stack_empty || (fm_reg < CNT_W'(NODE_COUNT));
    assign free_slot = stack_empty ? fm_reg[IDX_W-1:0] : top_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.give && !stack_full)
        begin
            stack_mem[rc_reg[IDX_W-1:0]] <= give_slot;
        end
        top_reg <= stack_mem[rc_m1[IDX_W-1:0]];
    end

    always_comb
    begin
        rc_next = rc_reg;
        fm_next = fm_reg;
        if (cmd.take)
        begin
            if (!stack_empty)
            begin
                rc_next = rc_m1;
            end
            else
            begin
                fm_next = fm_reg + 1'b1;
            end
        end
        else if (cmd.give && !stack_full)
        begin
            rc_next = rc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
            fm_reg <= CNT_W'(1);
        end
        else
        begin
            rc_reg <= rc_next;
            fm_reg <= fm_next;
        end
    end

endmodule

// ===== src/crl_ctrl.sv =====
// crl_ctrl: sequencer that walks each operation through the node memories
// depends on crl_pkg; drives crl_node_mem and crl_free_pool, holds the result register
`timescale 1ns / 1ps

module crl_ctrl #(
    parameter int NODE_COUNT  = crl_pkg::NODE_COUNT_DEF,
    parameter int VALUE_WIDTH = crl_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
    parameter int CNT_W       = $clog2(NODE_COUNT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [crl_pkg::FUNC_W-1:0]    func,
    input  logic [crl_pkg::ITEM_W-1:0]    item_value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [crl_pkg::ITEM_W-1:0]    current_value,
    output logic [crl_pkg::STATUS_W-1:0]  status,
    output logic                          at_start,
    output logic [crl_pkg::SIZE_W-1:0]    ring_size,
    output logic [IDX_W-1:0]              rd_addr,
    input  logic [IDX_W-1:0]              rd_next,
    input  logic [IDX_W-1:0]              rd_prev,
    input  logic [VALUE_WIDTH-1:0]        rd_val,
    output crl_pkg::node_wr_t             wr,
    output logic [IDX_W-1:0]              wa_next,
    output logic [IDX_W-1:0]              wd_next,
    output logic [IDX_W-1:0]              wa_prev,
    output logic [IDX_W-1:0]              wd_prev,
    output logic [IDX_W-1:0]              wa_val,
    output logic [VALUE_WIDTH-1:0]        wd_val,
    output crl_pkg::pool_cmd_t            pool_cmd,
    output logic [IDX_W-1:0]              give_slot,
    input  logic [IDX_W-1:0]              free_slot,
    input  logic                          avail
);
    import crl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_FETCH,
        S_LOAD
    } state_t;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       node_reg, node_next;
    logic [IDX_W-1:0]       nb_reg, nb_next;
    status_t                st_reg, st_next;

    logic                   out_valid_reg, out_valid_next;
    logic [ITEM_W-1:0]      cur_value_reg, cur_value_next;
    status_t                st_out_reg, st_out_next;
    logic                   at_start_reg, at_start_next;
    logic [SIZE_W-1:0]      size_reg, size_next;

    logic [63:0]            item_wide;
    logic [63:0]            rd_val_wide;
    logic                   can_push;

    assign item_wide   = 64'(item_value);
    assign rd_val_wide = 64'(rd_val);
    assign can_push    = (count_reg < CNT_W'(NODE_COUNT)) && avail;

    assign item_ready    = (state_reg == S_IDLE);
    assign rd_addr       = cursor_reg;
    assign give_slot     = cursor_reg;
    assign result_valid  = out_valid_reg;
    assign current_value = cur_value_reg;
    assign status        = st_out_reg;
    assign at_start      = at_start_reg;
    assign ring_size     = size_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        val_next       = val_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        node_next      = node_reg;
        nb_next        = nb_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        cur_value_next = cur_value_reg;
        st_out_next    = st_out_reg;
        at_start_next  = at_start_reg;
        size_next      = size_reg;

        wr       = '0;
        wa_next  = cursor_reg;
        wd_next  = node_reg;
        wa_prev  = cursor_reg;
        wd_prev  = node_reg;
        wa_val   = cursor_reg;
        wd_val   = val_reg;
        pool_cmd = '0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    func_next  = func_t'(func);
                    val_next   = item_wide[VALUE_WIDTH-1:0];
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FETCH;
                case (func_reg)
                    FN_PUSH_NEXT, FN_PUSH_PREV:
                    begin
                        if (!can_push)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            // fill the new node, splice it in on the next cycle
                            wr.wr_val     = 1'b1;
                            wr.wr_next    = 1'b1;
                            wr.wr_prev    = 1'b1;
                            wa_val        = free_slot;
                            wa_next       = free_slot;
                            wa_prev       = free_slot;
                            pool_cmd.take = 1'b1;
                            node_next     = free_slot;
                            count_next    = count_reg + 1'b1;
                            state_next    = S_LINK;
                            if (func_reg == FN_PUSH_NEXT)
                            begin
                                wd_next = rd_next;
                                wd_prev = cursor_reg;
                                nb_next = rd_next;
                            end
                            else
                            begin
                                wd_next = cursor_reg;
                                wd_prev = rd_prev;
                                nb_next = rd_prev;
                            end
                        end
                    end
                    FN_MOVE_NEXT:
                    begin
                        cursor_next = rd_next;
                    end
                    FN_MOVE_PREV:
                    begin
                        cursor_next = rd_prev;
                    end
                    FN_RENAME:
                    begin
                        wr.wr_val = 1'b1;
                    end
                    FN_DELETE:
                    begin
                        if (cursor_reg == '0)
                        begin
                            st_next = ST_START;
                        end
                        else
                        begin
                            wr.wr_next    = 1'b1;
                            wa_next       = rd_prev;
                            wd_next       = rd_next;
                            wr.wr_prev    = 1'b1;
                            wa_prev       = rd_next;
                            wd_prev       = rd_prev;
                            pool_cmd.give = 1'b1;
                            cursor_next   = rd_next;
                            if (count_reg > CNT_W'(1))
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    FN_REWIND:
                    begin
                        cursor_next = '0;
                    end
                    default:
                    begin
                        // read leaves everything as it is
                    end
                endcase
            end

            S_LINK:
            begin
                wr.wr_next  = 1'b1;
                wr.wr_prev  = 1'b1;
                wd_next     = node_reg;
                wd_prev     = node_reg;
                if (func_reg == FN_PUSH_NEXT)
                begin
                    wa_next = cursor_reg;
                    wa_prev = nb_reg;
                end
                else
                begin
                    wa_next = nb_reg;
                    wa_prev = cursor_reg;
                end
                cursor_next = node_reg;
                state_next  = S_FETCH;
            end

            S_FETCH:
            begin
                // memory read at the new cursor lands next cycle
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    cur_value_next = rd_val_wide[ITEM_W-1:0];
                    st_out_next    = st_reg;
                    at_start_next  = (cursor_reg == '0);
                    size_next      = SIZE_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FN_READ;
            st_reg        <= ST_OK;
            cursor_reg    <= '0;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            val_reg       <= '0;
            node_reg      <= '0;
            nb_reg        <= '0;
            cur_value_reg <= '0;
            st_out_reg    <= ST_OK;
            at_start_reg  <= 1'b0;
            size_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            st_reg        <= st_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            val_reg       <= val_next;
            node_reg      <= node_next;
            nb_reg        <= nb_next;
            cur_value_reg <= cur_value_next;
            st_out_reg    <= st_out_next;
            at_start_reg  <= at_start_next;
            size_reg      <= size_next;
        end
    end

endmodule

// ===== tb/crl_ring_checker.sv =====
// crl_ring_checker: watches both channels of cursor_linked_ring, keeps its own copy of the
// ring and compares each result with the expected cursor view; depends on crl_pkg
`timescale 1ns / 1ps

module crl_ring_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  logic [crl_pkg::FUNC_W-1:0]   func,
    input  logic [crl_pkg::ITEM_W-1:0]   item_value,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  logic [crl_pkg::ITEM_W-1:0]   current_value,
    input  logic [crl_pkg::STATUS_W-1:0] status,
    input  logic                         at_start,
    input  logic [crl_pkg::SIZE_W-1:0]   ring_size,
    output int                           errors,
    output int                           pending
);
    import crl_pkg::*;

    localparam int SLOTS = NODE_COUNT_DEF;

    typedef struct {
        logic [ITEM_W-1:0] value;
        status_t           st;
        logic              start;
        logic [SIZE_W-1:0] size;
    } cursor_view_t;

    logic [7:0]        link_fwd [SLOTS];
    logic [7:0]        link_back[SLOTS];
    logic [ITEM_W-1:0] slot_value[SLOTS];
    logic [7:0]        spare_stack[SLOTS];
    logic [7:0]        cur_slot;
    int                node_total;
    int                fresh_slot;
    int                spare_top;

    cursor_view_t expected_views[$];

    // pops a recycled slot first, else the next never-used one
    function automatic logic alloc_slot(output logic [7:0] got);
        begin
            alloc_slot = 1'b0;
            got = '0;
            if (node_total < SLOTS)
            begin
                if (spare_top > 0)
                begin
                    spare_top--;
                    got = spare_stack[spare_top];
                    alloc_slot = 1'b1;
                end
                else if (fresh_slot < SLOTS)
                begin
                    got = fresh_slot[7:0];
                    fresh_slot++;
                    alloc_slot = 1'b1;
                end
            end
        end
    endfunction

    function automatic cursor_view_t apply_op(input func_t op, input logic [ITEM_W-1:0] v);
        cursor_view_t view;
        logic [7:0]   fresh;
        logic [7:0]   nx;
        logic [7:0]   pv;
        begin
            view.st = ST_OK;
            case (op)
                FN_PUSH_NEXT, FN_PUSH_PREV:
                begin
                    if (!alloc_slot(fresh))
                    begin
                        view.st = ST_FULL;
                    end
                    else
                    begin
                        slot_value[fresh] = v;
                        if (op == FN_PUSH_NEXT)
                        begin
                            nx = link_fwd[cur_slot];
                            link_fwd[fresh] = nx;
                            link_back[fresh] = cur_slot;
                            link_back[nx] = fresh;
                            link_fwd[cur_slot] = fresh;
                        end
                        else
                        begin
                            pv = link_back[cur_slot];
                            link_fwd[fresh] = cur_slot;
                            link_back[fresh] = pv;
                            link_fwd[pv] = fresh;
                            link_back[cur_slot] = fresh;
                        end
                        cur_slot = fresh;
                        node_total++;
                    end
                end
                FN_MOVE_NEXT: cur_slot = link_fwd[cur_slot];
                FN_MOVE_PREV: cur_slot = link_back[cur_slot];
                FN_RENAME:    slot_value[cur_slot] = v;
                FN_DELETE:
                begin
                    if (cur_slot == 8'd0)
                    begin
                        view.st = ST_START;
                    end
                    else
                    begin
                        nx = link_fwd[cur_slot];
                        pv = link_back[cur_slot];
                        link_fwd[pv] = nx;
                        link_back[nx] = pv;
                        if (spare_top < SLOTS)
                        begin
                            spare_stack[spare_top] = cur_slot;
                            spare_top++;
                        end
                        cur_slot = nx;
                        if (node_total > 1)
                            node_total--;
                    end
                end
                FN_REWIND:    cur_slot = 8'd0;
                default:      ;
            endcase
            view.value = slot_value[cur_slot];
            view.start = (cur_slot == 8'd0);
            view.size  = node_total[SIZE_W-1:0];
            return view;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_view_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                link_fwd[i]    = '0;
                link_back[i]   = '0;
                slot_value[i]  = '0;
                spare_stack[i] = '0;
            end
            cur_slot   = '0;
            node_total = 1;
            fresh_slot = 1;
            spare_top  = 0;
            expected_views.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_views.push_back(apply_op(func_t'(func), item_value));
            if (result_valid && result_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result transaction with no operation outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (current_value !== want.value)
                    begin
                        $error("current_value: expected %h, got %h", want.value, current_value);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        errors++;
                    end
                    if (at_start !== want.start)
                    begin
                        $error("at_start: expected %0d, got %0d", want.start, at_start);
                        errors++;
                    end
                    if (ring_size !== want.size)
                    begin
                        $error("ring_size: expected %0d, got %0d", want.size, ring_size);
                        errors++;
                    end
                end
            end
            pending = expected_views.size();
        end
    end

endmodule

// ===== tb/tb_cursor_linked_ring.sv =====
// tb_cursor_linked_ring: drives operations into cursor_linked_ring with random gaps and stalls
// depends on crl_pkg, the block under src and crl_ring_checker
`timescale 1ns / 1ps

module tb_cursor_linked_ring;
    import crl_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [FUNC_W-1:0]   func;
    logic [ITEM_W-1:0]   item_value;
    logic                result_valid;
    logic                result_ready;
    logic [ITEM_W-1:0]   current_value;
    logic [STATUS_W-1:0] status;
    logic                at_start;
    logic [SIZE_W-1:0]   ring_size;
    int                  errors;
    int                  pending;
    bit                  steady;

    cursor_linked_ring i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .item_value    (item_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .current_value (current_value),
        .status        (status),
        .at_start      (at_start),
        .ring_size     (ring_size)
    );

    crl_ring_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .item_value    (item_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .current_value (current_value),
        .status        (status),
        .at_start      (at_start),
        .ring_size     (ring_size),
        .errors        (errors),
        .pending       (pending)
    );

    always #10 clk = ~clk;

    // receiver stalls, except while steady is set
    always @(negedge clk)
    begin
        if (steady)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 99) >= 31);
    end

    task automatic send_op(input func_t op, input logic [ITEM_W-1:0] v);
        begin
            @(negedge clk);
            while (!steady && $urandom_range(0, 99) < 31)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
            item_valid <= 1'b1;
            func       <= op;
            item_value <= v;
            do @(posedge clk); while (!item_ready);
        end
    endtask

    function automatic logic [ITEM_W-1:0] rand_value();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                return '0;
            else if (r < 10)
                return '1;
            return $urandom;
        end
    endfunction

    function automatic func_t rand_op(input int push_pct, input int del_pct);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                return $urandom_range(0, 1) ? FN_PUSH_PREV : FN_PUSH_NEXT;
            if (r < push_pct + del_pct)
                return FN_DELETE;
            case ($urandom_range(0, 4))
                0:       return FN_MOVE_NEXT;
                1:       return FN_MOVE_PREV;
                2:       return FN_READ;
                3:       return FN_RENAME;
                default: return FN_REWIND;
            endcase
        end
    endfunction

    task automatic run_phase(input int n, input int push_pct, input int del_pct);
        begin
            for (int i = 0; i < n; i++)
                send_op(rand_op(push_pct, del_pct), rand_value());
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        func         = FN_READ;
        item_value   = '0;
        steady       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: operations on the lone start node, then a small ring
        send_op(FN_DELETE,    32'h1234_5678);
        send_op(FN_READ,      32'hFFFF_FFFF);
        send_op(FN_MOVE_NEXT, '0);
        send_op(FN_MOVE_PREV, '0);
        send_op(FN_REWIND,    '0);
        send_op(FN_RENAME,    32'hFFFF_FFFF);
        send_op(FN_PUSH_NEXT, 32'h0000_0000);
        send_op(FN_PUSH_PREV, 32'hFFFF_FFFF);
        send_op(FN_MOVE_NEXT, '0);
        send_op(FN_MOVE_NEXT, '0);
        send_op(FN_MOVE_PREV, '0);
        send_op(FN_RENAME,    32'hA5A5_A5A5);
        send_op(FN_READ,      '0);
        send_op(FN_DELETE,    '0);
        send_op(FN_DELETE,    '0);
        send_op(FN_PUSH_NEXT, 32'h5A5A_5A5A);
        send_op(FN_PUSH_PREV, 32'h8000_0001);
        send_op(FN_REWIND,    '0);
        send_op(FN_MOVE_PREV, '0);
        send_op(FN_DELETE,    '0);
        send_op(FN_DELETE,    '0);
        send_op(FN_DELETE,    '0);
        send_op(FN_DELETE,    '0);

        // fill the store past full, first stretch without any idling
        steady = 1'b1;
        run_phase(150, 90, 4);
        steady = 1'b0;
        run_phase(180, 90, 4);
        run_phase(150, 30, 20);
        // drain: deletes outnumber pushes, recycled slots get reused
        run_phase(250, 15, 45);

        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/crl_pkg.sv
src/crl_node_mem.sv
src/crl_free_pool.sv
src/crl_ctrl.sv
src/cursor_linked_ring.sv
tb/crl_ring_checker.sv
tb/tb_cursor_linked_ring.sv
